>>> design/ptts_pkg.sv
// Shared types, constants and helper functions for the preemptive tick scheduler.
// No dependencies; used by ptts_release and preemptive_tick_task_scheduler.
package ptts_pkg;

  // Slot and field geometry.
  localparam int NUM_SLOTS     = 4;
  localparam int TIME_BITS     = 16;
  localparam int BUDGET_BITS   = 8;
  localparam int LANES         = NUM_SLOTS - 1;
  localparam int SLOT_BITS     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_BITS      = $clog2(TIME_BITS + 1);
  localparam int BYTE_BITS     = 8;
  localparam int PERIOD_BITS   = 8;
  localparam int ID_BITS       = 8;
  localparam int OUT_SLOT_BITS = 2;
  localparam int REG_BITS      = 32;
  localparam int MASK_BITS     = 4;
  localparam int CFG_IDX_BITS  = 2;

  // Stream widths: input holds tick_time then sporadic_release, padded to bytes.
  localparam int IN_BITS        = TIME_BITS + 1;
  localparam int IN_TDATA_BITS  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS       = ID_BITS + OUT_SLOT_BITS + 2;
  localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_IDS      = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PERIODS  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PERIODIC = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_BUDGETS  = 2'd3;

  // Register values after reset.
  localparam logic [REG_BITS-1:0]  RESET_IDS      = 32'h0403_0201;
  localparam logic [REG_BITS-1:0]  RESET_PERIODS  = 32'h0404_0404;
  localparam logic [MASK_BITS-1:0] RESET_PERIODIC = 4'h6;
  localparam logic [REG_BITS-1:0]  RESET_BUDGETS  = 32'h0101_0201;

  // Status from the release unit to the scheduler core.
  typedef struct packed {
    logic             done;
    logic [LANES-1:0] set;
  } rel_status_t;

  // Byte of a per-slot register; slots past the register read zero.
  function automatic logic [BYTE_BITS-1:0] slot_byte(logic [REG_BITS-1:0] r,
                                                     logic [SLOT_BITS-1:0] idx);
    logic [REG_BITS-1:0] sh;
    sh = r >> (BYTE_BITS * idx);
    return sh[BYTE_BITS-1:0];
  endfunction

  // Periodic flag of a slot; slots past the mask read zero.
  function automatic logic mask_bit(logic [MASK_BITS-1:0] m, logic [SLOT_BITS-1:0] idx);
    logic [MASK_BITS-1:0] sh;
    sh = m >> idx;
    return sh[0];
  endfunction

  // Per-activation budget of a slot, cut or extended to the counter width.
  function automatic logic [BUDGET_BITS-1:0] budget_of(logic [REG_BITS-1:0] r,
                                                      logic [SLOT_BITS-1:0] idx);
    return BUDGET_BITS'(slot_byte(r, idx));
  endfunction

endpackage

>>> design/preemptive_tick_task_scheduler.sv
// Fixed-priority preemptive tick scheduler: one result transfer per tick transfer.
// Each tick runs the bit-serial period remainder in ptts_release and is then committed to
// the result register; a new tick is accepted only after the previous one has committed.
// A waiting result does not block the next tick's release test; commit waits for the slot.
// Synchronous reset restores register defaults, clears ready, running and busy state
// and reloads every remaining budget from the default budgets.
module preemptive_tick_task_scheduler (
  input  logic                                   clk,
  input  logic                                   rst,
  // Fields from bit 0: tick_time[15:0], sporadic_release[16], zero padding.
  input  logic [ptts_pkg::IN_TDATA_BITS-1:0]     s_tdata,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // Fields from bit 0: chosen_id[7:0], chosen_slot[9:8], preempted[10], finished[11].
  output logic [ptts_pkg::OUT_TDATA_BITS-1:0]    m_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  input  logic                                   cfg_we,
  input  logic [ptts_pkg::CFG_IDX_BITS-1:0]      cfg_idx,
  input  logic [ptts_pkg::REG_BITS-1:0]          cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_CALC   = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

  localparam logic [ptts_pkg::SLOT_BITS-1:0] LAST = ptts_pkg::SLOT_BITS'(ptts_pkg::LANES);

  state_t                             state;
  state_t                             state_next;
  logic [ptts_pkg::REG_BITS-1:0]      slot_ids;
  logic [ptts_pkg::REG_BITS-1:0]      slot_periods;
  logic [ptts_pkg::MASK_BITS-1:0]     periodic_mask;
  logic [ptts_pkg::REG_BITS-1:0]      slot_budgets;
  logic [ptts_pkg::NUM_SLOTS-1:0]     ready_q;
  logic [ptts_pkg::NUM_SLOTS-1:0]     running_q;
  logic                               busy_q;
  logic [ptts_pkg::BUDGET_BITS-1:0]   remaining_budget [ptts_pkg::NUM_SLOTS];
  ptts_pkg::rel_status_t              rel_status;
  logic                               accept;
  logic                               out_free;
  logic                               commit;
  logic [ptts_pkg::NUM_SLOTS-1:0]     ready_all;
  logic [ptts_pkg::SLOT_BITS-1:0]     chosen;
  logic                               have_store;
  logic [ptts_pkg::SLOT_BITS-1:0]     store;
  logic                               active;
  logic [ptts_pkg::BUDGET_BITS-1:0]   budget_dec;
  logic                               pre;
  logic                               fin;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  ptts_release u_release (
    .clk              (clk),
    .rst              (rst),
    .start            (accept),
    .tick_time        (s_tdata[ptts_pkg::TIME_BITS-1:0]),
    .sporadic_release (s_tdata[ptts_pkg::TIME_BITS]),
    .slot_periods     (slot_periods),
    .periodic_mask    (periodic_mask),
    .status           (rel_status)
  );

  // Sequence: release test, then commit once the output register is free.
  always_comb begin
    state_next = state;
    commit     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_CALC;
      end
      ST_CALC: begin
        if (rel_status.done) begin
          if (out_free) begin
            commit     = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_COMMIT;
          end
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          commit     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Pick the lowest-numbered ready slot and the lowest-numbered slot that was running.
  always_comb begin
    ready_all  = ready_q | {1'b0, rel_status.set};
    chosen     = LAST;
    have_store = 1'b0;
    store      = '0;
    for (int i = ptts_pkg::LANES - 1; i >= 0; i--) begin
      if (ready_all[i]) chosen = ptts_pkg::SLOT_BITS'(i);
      if (busy_q && running_q[i]) begin
        have_store = 1'b1;
        store      = ptts_pkg::SLOT_BITS'(i);
      end
    end
    active = (chosen != LAST);
    if (remaining_budget[chosen] != '0) begin
      budget_dec = ptts_pkg::BUDGET_BITS'(remaining_budget[chosen] - 1'b1);
    end else begin
      budget_dec = '0;
    end
    pre = active && have_store && (chosen < store);
    fin = active && (budget_dec == '0);
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      slot_ids      <= ptts_pkg::RESET_IDS;
      slot_periods  <= ptts_pkg::RESET_PERIODS;
      periodic_mask <= ptts_pkg::RESET_PERIODIC;
      slot_budgets  <= ptts_pkg::RESET_BUDGETS;
      ready_q       <= '0;
      running_q     <= '0;
      busy_q        <= 1'b0;
      m_tvalid      <= 1'b0;
      for (int i = 0; i < ptts_pkg::NUM_SLOTS; i++) begin
        remaining_budget[i] <= ptts_pkg::budget_of(ptts_pkg::RESET_BUDGETS,
                                                   ptts_pkg::SLOT_BITS'(i));
      end
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_idx)
          ptts_pkg::REG_IDS:      slot_ids      <= cfg_wdata;
          ptts_pkg::REG_PERIODS:  slot_periods  <= cfg_wdata;
          ptts_pkg::REG_PERIODIC: periodic_mask <= cfg_wdata[ptts_pkg::MASK_BITS-1:0];
          ptts_pkg::REG_BUDGETS:  slot_budgets  <= cfg_wdata;
          default: ;
        endcase
      end
      if (commit) begin
        m_tvalid <= 1'b1;
        if (active) begin
          if (fin) begin
            ready_q                  <= ready_all & ~(ptts_pkg::NUM_SLOTS'(1) << chosen);
            running_q                <= running_q & ~(ptts_pkg::NUM_SLOTS'(1) << chosen);
            busy_q                   <= 1'b0;
            remaining_budget[chosen] <= ptts_pkg::budget_of(slot_budgets, chosen);
          end else begin
            ready_q                  <= ready_all;
            running_q                <= running_q | (ptts_pkg::NUM_SLOTS'(1) << chosen);
            busy_q                   <= 1'b1;
            remaining_budget[chosen] <= budget_dec;
          end
        end else begin
          ready_q <= ready_all;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= ptts_pkg::OUT_TDATA_BITS'({fin, pre,
                                            ptts_pkg::OUT_SLOT_BITS'(chosen),
                                            ptts_pkg::slot_byte(slot_ids, chosen)});
    end
  end

`ifndef SYNTHESIS
  // The idle slot is never marked ready.
  a_idle_never_ready: assert property (@(posedge clk) disable iff (rst)
    !ready_q[LAST])
    else $error("idle slot marked ready");

  // A busy scheduler always has some slot running.
  a_busy_has_running: assert property (@(posedge clk) disable iff (rst)
    busy_q |-> (running_q != '0))
    else $error("busy with no running slot");

  // A finished slot leaves neither ready nor running.
  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    (commit && fin) |=> (!ready_q[$past(chosen)] && !running_q[$past(chosen)]))
    else $error("finished slot still ready or running");

  // The release test completes only while a tick is being worked.
  a_done_in_calc: assert property (@(posedge clk) disable iff (rst)
    rel_status.done |-> (state == ST_CALC))
    else $error("release result outside calculation");

  // An idle result carries neither preempted nor finished.
  a_idle_result: assert property (@(posedge clk) disable iff (rst)
    (commit && !active) |-> (!pre && !fin))
    else $error("idle tick flagged");
`endif

endmodule

>>> design/ptts_release.sv
// Release test for all non-idle slots: bit-serial remainder of the tick time by each period.
// Depends on ptts_pkg.
module ptts_release (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [ptts_pkg::TIME_BITS-1:0]     tick_time,
  input  logic                               sporadic_release,
  input  logic [ptts_pkg::REG_BITS-1:0]      slot_periods,
  input  logic [ptts_pkg::MASK_BITS-1:0]     periodic_mask,
  output ptts_pkg::rel_status_t              status
);

  logic [ptts_pkg::TIME_BITS-1:0]   time_sr;
  logic [ptts_pkg::CNT_BITS-1:0]    cnt;
  logic                             done_q;
  logic                             rel_q;
  logic [ptts_pkg::PERIOD_BITS-1:0] rem      [ptts_pkg::LANES];
  logic [ptts_pkg::PERIOD_BITS-1:0] rem_next [ptts_pkg::LANES];
  logic [ptts_pkg::LANES-1:0]       set;

  // One restoring step per lane: shift in the next time bit, subtract the period if it fits.
  always_comb begin
    for (int i = 0; i < ptts_pkg::LANES; i++) begin
      logic [ptts_pkg::PERIOD_BITS:0]   wide;
      logic [ptts_pkg::PERIOD_BITS-1:0] p;
      p    = ptts_pkg::slot_byte(slot_periods, ptts_pkg::SLOT_BITS'(i));
      wide = {rem[i], time_sr[ptts_pkg::TIME_BITS-1]};
      if (wide >= {1'b0, p}) begin
        rem_next[i] = ptts_pkg::PERIOD_BITS'(wide - {1'b0, p});
      end else begin
        rem_next[i] = ptts_pkg::PERIOD_BITS'(wide);
      end
    end
  end

  // Sequencer: one time bit per cycle, most significant first.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt == ptts_pkg::CNT_BITS'(1)) && !start;
      if (start) begin
        cnt <= ptts_pkg::CNT_BITS'(ptts_pkg::TIME_BITS);
      end else if (cnt != '0) begin
        cnt <= ptts_pkg::CNT_BITS'(cnt - 1'b1);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      time_sr <= tick_time;
      rel_q   <= sporadic_release;
      for (int i = 0; i < ptts_pkg::LANES; i++) begin
        rem[i] <= '0;
      end
    end else if (cnt != '0) begin
      time_sr <= {time_sr[ptts_pkg::TIME_BITS-2:0], 1'b0};
      for (int i = 0; i < ptts_pkg::LANES; i++) begin
        rem[i] <= rem_next[i];
      end
    end
  end

  // A periodic slot is released on a zero remainder by a nonzero period; other slots follow the sporadic flag.
  always_comb begin
    for (int i = 0; i < ptts_pkg::LANES; i++) begin
      if (ptts_pkg::mask_bit(periodic_mask, ptts_pkg::SLOT_BITS'(i))) begin
        set[i] = (ptts_pkg::slot_byte(slot_periods, ptts_pkg::SLOT_BITS'(i)) != '0) &&
                 (rem[i] == '0);
      end else begin
        set[i] = rel_q;
      end
    end
  end

  assign status.done = done_q;
  assign status.set  = set;

endmodule

>>> verif/preemptive_tick_task_scheduler_test.sv
// Self-checking testbench for the preemptive tick scheduler: directed and random ticks
// under several register settings, checked against a scheduler model kept in this file.
// Depends on ptts_pkg and preemptive_tick_task_scheduler from the design folder.
module preemptive_tick_task_scheduler_test;
  import ptts_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int QUIET_CYCLES = TIME_BITS + 8;

  // One result transfer, first field in the lowest bits.
  typedef struct packed {
    logic                     finished;
    logic                     preempted;
    logic [OUT_SLOT_BITS-1:0] slot;
    logic [ID_BITS-1:0]       id;
  } tick_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic [IN_TDATA_BITS-1:0]  s_tdata = '0;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [OUT_TDATA_BITS-1:0] m_tdata;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]   cfg_idx = '0;
  logic [REG_BITS-1:0]       cfg_wdata = '0;

  // Scheduler model: register copies and task state.
  logic [REG_BITS-1:0]    cfg_ids;
  logic [REG_BITS-1:0]    cfg_periods;
  logic [MASK_BITS-1:0]   cfg_mask;
  logic [REG_BITS-1:0]    cfg_budgets;
  logic [LANES-1:0]       ready_bits;
  logic [LANES-1:0]       run_bits;
  logic [BUDGET_BITS-1:0] left_budget [NUM_SLOTS];
  logic                   busy;

  tick_result_t expected_results[$];

  int unsigned cycles = 0;
  int          errors = 0;
  int          ticks_sent = 0;
  int          results_seen = 0;
  int          preempt_seen = 0;
  int          finish_seen = 0;
  int          idle_seen = 0;
  int          settings_used = 0;

  // Sender burst shape and receiver stall pattern.
  int          burst_left = 0;
  int          gap_max = 0;
  logic        stall_off = 1'b1;
  logic [7:0]  ready_pattern = 8'hFF;
  int          pattern_step = 0;

  preemptive_tick_task_scheduler u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case a transfer never completes.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles,
               expected_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Model state after reset.
  task automatic reset_model();
    cfg_ids     = RESET_IDS;
    cfg_periods = RESET_PERIODS;
    cfg_mask    = RESET_PERIODIC;
    cfg_budgets = RESET_BUDGETS;
    ready_bits  = '0;
    run_bits    = '0;
    busy        = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      left_budget[i] = cfg_budgets[8*i +: 8];
    end
  endtask

  // Advances the model by one tick and returns the result it should produce.
  function automatic tick_result_t schedule_tick(input logic [TIME_BITS-1:0] t,
                                                 input logic rel);
    tick_result_t res;
    int pick;
    int prev;
    logic [PERIOD_BITS-1:0] per;
    logic [BUDGET_BITS-1:0] left;
    pick = NUM_SLOTS - 1;
    prev = -1;
    res = '0;
    // Release: periodic slots on a period boundary, sporadic slots on the flag.
    for (int i = 0; i < LANES; i++) begin
      per = cfg_periods[8*i +: 8];
      if (cfg_mask[i]) begin
        if (per != 0 && (t % per) == 0) ready_bits[i] = 1'b1;
      end else if (rel) begin
        ready_bits[i] = 1'b1;
      end
    end
    // Lowest-numbered slot that was running, and lowest-numbered slot now ready.
    for (int i = LANES - 1; i >= 0; i--) begin
      if (busy && run_bits[i]) prev = i;
      if (ready_bits[i]) pick = i;
    end
    if (pick != NUM_SLOTS - 1) begin
      left = left_budget[pick];
      left = (left > 0) ? left - 1'b1 : '0;
      left_budget[pick] = left;
      run_bits[pick] = 1'b1;
      busy = 1'b1;
      if (prev >= 0 && pick < prev) res.preempted = 1'b1;
      // Budget spent: reload and retire the activation.
      if (left == 0) begin
        run_bits[pick]    = 1'b0;
        ready_bits[pick]  = 1'b0;
        left_budget[pick] = cfg_budgets[8*pick +: 8];
        busy              = 1'b0;
        res.finished      = 1'b1;
      end
    end
    res.slot = OUT_SLOT_BITS'(pick);
    res.id   = cfg_ids[8*pick +: 8];
    return res;
  endfunction

  // One register write; the enable is lowered again after it.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [REG_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_IDS:      cfg_ids     = val;
      REG_PERIODS:  cfg_periods = val;
      REG_PERIODIC: cfg_mask    = val[MASK_BITS-1:0];
      REG_BUDGETS:  cfg_budgets = val;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Sender pauses until every expected result has arrived and the block is quiet.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [REG_BITS-1:0] ids, input logic [REG_BITS-1:0] pers,
                               input logic [MASK_BITS-1:0] mask,
                               input logic [REG_BITS-1:0] buds);
    drain();
    write_reg(REG_IDS, ids);
    write_reg(REG_PERIODS, pers);
    write_reg(REG_PERIODIC, REG_BITS'(mask));
    write_reg(REG_BUDGETS, buds);
    settings_used++;
  endtask

  // One tick transfer; valid stays high so that a burst continues without a drop.
  task automatic send_tick(input logic [TIME_BITS-1:0] t, input logic rel);
    logic [IN_TDATA_BITS-1:0] word;
    word = '0;
    word[TIME_BITS-1:0] = t;
    word[TIME_BITS] = rel;
    s_tdata  <= word;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_results.push_back(schedule_tick(t, rel));
    ticks_sent++;
    // End of burst: lower valid for a random gap.
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gap_max != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Random register byte per slot: mostly small, sometimes zero or any value.
  function automatic logic [REG_BITS-1:0] pick_bytes(input int small_max);
    logic [REG_BITS-1:0] v;
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 9))
        0:       v[8*i +: 8] = 8'h00;
        1:       v[8*i +: 8] = 8'($urandom);
        2:       v[8*i +: 8] = 8'hFF;
        default: v[8*i +: 8] = 8'($urandom_range(1, small_max));
      endcase
    end
    // The idle slot's byte keeps the register inside its legal range.
    if (v[31:24] == 8'h00) v[31:24] = 8'h01;
    return v;
  endfunction

  // Receiver: stalls follow a rotating pattern that is reloaded when pattern_step wraps.
  always @(posedge clk) begin
    if (pattern_step == 7) begin
      ready_pattern <= 8'($urandom) | 8'h01;
      pattern_step  <= 0;
    end else begin
      ready_pattern <= {ready_pattern[0], ready_pattern[7:1]};
      pattern_step  <= pattern_step + 1;
    end
    m_tready <= stall_off | ready_pattern[0];
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // Compares each result transfer with the oldest expectation.
  always @(posedge clk) begin : result_check
    tick_result_t want;
    tick_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[OUT_BITS-1:0];
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, actual id %0d slot %0d", $time, got.id,
                 got.slot);
      end else begin
        want = expected_results.pop_front();
        results_seen++;
        check_field("chosen_id", want.id, got.id);
        check_field("chosen_slot", want.slot, got.slot);
        check_field("preempted", want.preempted, got.preempted);
        check_field("finished", want.finished, got.finished);
        if (want.preempted) preempt_seen++;
        if (want.finished) finish_seen++;
        if (want.slot == NUM_SLOTS - 1) idle_seen++;
      end
    end
  end

  // Reset settings: periodic slots at period four, sporadic slot 0, time extremes.
  task automatic test_reset_settings();
    gap_max = 0;
    stall_off = 1'b1;
    for (int t = 0; t < 6; t++) send_tick(TIME_BITS'(t), t[0]);
    send_tick(16'hFFFF, 1'b0);
    send_tick(16'h8000, 1'b1);
    send_tick(16'h7FFF, 1'b1);
  endtask

  // Zero periods never release; zero budgets finish on the first tick.
  task automatic test_zero_cases();
    apply_setting(32'h0000_0000, 32'h0400_0100, 4'hF, 32'h0100_0200);
    for (int t = 0; t < 4; t++) send_tick(TIME_BITS'(t), 1'b1);
    apply_setting(32'h0000_0000, 32'h0400_0100, 4'h0, 32'h0100_0200);
    send_tick(16'd9, 1'b1);
    send_tick(16'd10, 1'b0);
    send_tick(16'd11, 1'b0);
    send_tick(16'd12, 1'b0);
  endtask

  // Slot 2 runs periodically and the sporadic slot 0 displaces it.
  task automatic test_preemption();
    apply_setting(32'hFFFF_FFFF, 32'h0101_0000, 4'h6, 32'h0105_0102);
    send_tick(16'd1, 1'b0);
    send_tick(16'd2, 1'b1);
    send_tick(16'd3, 1'b0);
    send_tick(16'd4, 1'b0);
    send_tick(16'd5, 1'b1);
    send_tick(16'd6, 1'b0);
    send_tick(16'd7, 1'b0);
  endtask

  // Random phases: new settings each phase, mostly consecutive tick times.
  task automatic test_random_phases();
    logic [TIME_BITS-1:0] now;
    int rel_pct;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF);
        1: apply_setting(32'h0000_0000, 32'h0101_0101, 4'h0, 32'h0101_0101);
        default: apply_setting($urandom, pick_bytes(8), 4'($urandom_range(0, 15)),
                               pick_bytes(6));
      endcase
      gap_max   = (phase % 3 == 0) ? 0 : $urandom_range(1, 15);
      stall_off = (phase % 4 == 1);
      rel_pct   = $urandom_range(0, 60);
      now       = TIME_BITS'($urandom);
      for (int n = 0; n < 83; n++) begin
        if ($urandom_range(0, 19) == 0) now = TIME_BITS'($urandom);
        else now = now + 1'b1;
        send_tick(now, $urandom_range(0, 99) < rel_pct);
        // Once mid-run, wait for every result before going on.
        if (phase == 5 && n == 40) drain();
      end
    end
  endtask

  initial begin
    reset_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_settings();
    test_zero_cases();
    test_preemption();
    test_random_phases();
    drain();
    $display("Ticks sent %0d, results checked %0d, register settings %0d.", ticks_sent,
             results_seen, settings_used + 1);
    $display("Results with preemption %0d, finished activations %0d, idle ticks %0d.",
             preempt_seen, finish_seen, idle_seen);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches.", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
